// ===== sv/ipv4tp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4tp_pkg
// Shared types and constants for the dotted-decimal IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4tp_pkg;

  // character codes
  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // largest legal segment value
  localparam logic [9:0] MaxSegment = 10'd255;

  // segment position limits
  localparam logic [1:0] LastDot   = 2'd3;
  localparam logic [1:0] MaxDigits = 2'd3;

  // character class
  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_DOT,
    KIND_OTHER
  } kind_e;

  // classified beat passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
    logic       has_char;
    logic       ends;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } res_t;

endpackage

// ===== sv/ipv4tp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4tp_front
// Accepts text beats, classifies each character and holds them in a
// two-entry queue for the parser back end.
// ----------------------------------------------------------------------------
module ipv4tp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        character_i,
  input  logic              last_i,
  input  logic              no_char_i,
  output logic              beat_valid_o,
  output ipv4tp_pkg::beat_t beat_o,
  input  logic              beat_take_i
);

  ipv4tp_pkg::beat_t mem_q [2];
  ipv4tp_pkg::beat_t cls;
  logic [1:0]        cnt_q, cnt_d;
  logic              wr_ptr_q, rd_ptr_q;
  logic              do_wr, do_rd;

  // character classification
  always_comb begin
    cls          = '0;
    cls.has_char = ~no_char_i;
    cls.ends     = no_char_i | last_i;
    cls.digit    = 4'(character_i - ipv4tp_pkg::CharZero);
    if (character_i inside {[ipv4tp_pkg::CharZero:ipv4tp_pkg::CharNine]}) begin
      cls.kind = ipv4tp_pkg::KIND_DIGIT;
    end else if (character_i == ipv4tp_pkg::CharDot) begin
      cls.kind = ipv4tp_pkg::KIND_DOT;
    end else begin
      cls.kind = ipv4tp_pkg::KIND_OTHER;
    end
  end

  // queue handshake
  assign full         = (cnt_q == 2'd2);
  assign do_wr        = push & ~full;
  assign beat_valid_o = (cnt_q != 2'd0);
  assign do_rd        = beat_take_i & beat_valid_o;
  assign beat_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== sv/ipv4tp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4tp_back
// Runs the per-character parse state and places one result per finished
// string into a two-entry result queue.
// ----------------------------------------------------------------------------
module ipv4tp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_valid_i,
  input  ipv4tp_pkg::beat_t beat_i,
  output logic              beat_take_o,
  output logic              empty,
  input  logic              pop,
  output logic              valid_res_o,
  output logic [31:0]       address_o
);

  logic [1:0]  dots_q, dots_d;
  logic [1:0]  digits_q, digits_d;
  logic [9:0]  seg_q, seg_d;
  logic        lz_q, lz_d;
  logic        bad_q, bad_d;
  logic [31:0] part_q, part_d;
  logic [31:0] seg_shifted;
  logic        ok;

  ipv4tp_pkg::res_t res_mem_q [2];
  ipv4tp_pkg::res_t res_new;
  logic [1:0]       res_cnt_q, res_cnt_d;
  logic             res_wr_ptr_q, res_rd_ptr_q;
  logic             res_wr, res_rd;

  // take a beat while the result queue has room
  assign res_rd      = pop & ~empty;
  assign beat_take_o = beat_valid_i & ((res_cnt_q != 2'd2) | res_rd);
  assign res_wr      = beat_take_o & beat_i.ends;

  // finished segment placed at its byte position
  always_comb begin
    case (dots_q)
      2'd0:    seg_shifted = {seg_q[7:0], 24'd0};
      2'd1:    seg_shifted = {8'd0, seg_q[7:0], 16'd0};
      2'd2:    seg_shifted = {16'd0, seg_q[7:0], 8'd0};
      default: seg_shifted = 32'd0;
    endcase
  end

  // parse state update
  always_comb begin
    dots_d   = dots_q;
    digits_d = digits_q;
    seg_d    = seg_q;
    lz_d     = lz_q;
    bad_d    = bad_q;
    part_d   = part_q;
    if (beat_i.has_char && !bad_q) begin
      case (beat_i.kind)
        ipv4tp_pkg::KIND_DOT: begin
          if (digits_q == 2'd0 || dots_q == ipv4tp_pkg::LastDot ||
              seg_q > ipv4tp_pkg::MaxSegment) begin
            bad_d = 1'b1;
          end else begin
            part_d   = part_q | seg_shifted;
            dots_d   = dots_q + 2'd1;
            digits_d = 2'd0;
            seg_d    = 10'd0;
            lz_d     = 1'b0;
          end
        end
        ipv4tp_pkg::KIND_DIGIT: begin
          if (digits_q == ipv4tp_pkg::MaxDigits || (digits_q != 2'd0 && lz_q)) begin
            bad_d = 1'b1;
          end else begin
            if (digits_q == 2'd0 && beat_i.digit == 4'd0) begin
              lz_d = 1'b1;
            end
            seg_d    = {seg_q[6:0], 3'd0} + {seg_q[8:0], 1'b0} + {6'd0, beat_i.digit};
            digits_d = digits_q + 2'd1;
          end
        end
        default: begin
          bad_d = 1'b1;
        end
      endcase
    end
  end

  // verdict on the string as it stands after this beat
  always_comb begin
    ok = ~bad_d & (dots_d == ipv4tp_pkg::LastDot) & (digits_d != 2'd0) &
         (seg_d <= ipv4tp_pkg::MaxSegment);
    res_new.valid_res = ok;
    res_new.address   = ok ? (part_d | {24'd0, seg_d[7:0]}) : 32'd0;
  end

  // parse state registers, cleared after each string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dots_q   <= 2'd0;
      digits_q <= 2'd0;
      seg_q    <= 10'd0;
      lz_q     <= 1'b0;
      bad_q    <= 1'b0;
      part_q   <= 32'd0;
    end else if (beat_take_o) begin
      if (beat_i.ends) begin
        dots_q   <= 2'd0;
        digits_q <= 2'd0;
        seg_q    <= 10'd0;
        lz_q     <= 1'b0;
        bad_q    <= 1'b0;
        part_q   <= 32'd0;
      end else begin
        dots_q   <= dots_d;
        digits_q <= digits_d;
        seg_q    <= seg_d;
        lz_q     <= lz_d;
        bad_q    <= bad_d;
        part_q   <= part_d;
      end
    end
  end

  // result queue count
  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_wr && !res_rd) begin
      res_cnt_d = res_cnt_q + 2'd1;
    end else if (!res_wr && res_rd) begin
      res_cnt_d = res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q    <= 2'd0;
      res_wr_ptr_q <= 1'b0;
      res_rd_ptr_q <= 1'b0;
    end else begin
      res_cnt_q <= res_cnt_d;
      if (res_wr) begin
        res_wr_ptr_q <= ~res_wr_ptr_q;
      end
      if (res_rd) begin
        res_rd_ptr_q <= ~res_rd_ptr_q;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_mem_q[res_wr_ptr_q] <= res_new;
    end
  end

  // oldest result on the ports
  assign empty       = (res_cnt_q == 2'd0);
  assign valid_res_o = res_mem_q[res_rd_ptr_q].valid_res;
  assign address_o   = res_mem_q[res_rd_ptr_q].address;

endmodule

// ===== sv/ipv4_text_address_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_text_address_parser
// Strict dotted-decimal IPv4 text parser, one character per beat.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock and keeps that rate as long as
// results are popped. A beat enters a two-entry classification queue in the
// front end; the back end updates the parse state as it takes each beat and
// writes one result per finished string into a two-entry result queue; a
// string's result passes the front queue and then the result queue. Either
// queue absorbs stalls on its own side; full rises only when the front queue
// holds two beats that the back end cannot take.

module ipv4_text_address_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  input  logic        no_char_i,
  output logic        empty,
  input  logic        pop,
  output logic        valid_res_o,
  output logic [31:0] address_o
);

  logic              beat_valid;
  logic              beat_take;
  ipv4tp_pkg::beat_t beat;

  // classify and queue characters
  ipv4tp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .character_i  (character_i),
    .last_i       (last_i),
    .no_char_i    (no_char_i),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .beat_take_i  (beat_take)
  );

  // parse and deliver results
  ipv4tp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .beat_take_o  (beat_take),
    .empty        (empty),
    .pop          (pop),
    .valid_res_o  (valid_res_o),
    .address_o    (address_o)
  );

endmodule

// ===== sv/ipv4tp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4tp_checker
// Port-level checks for the IPv4 text parser, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4tp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        last_i,
  input logic        no_char_i,
  input logic        empty,
  input logic        pop,
  input logic        valid_res_o,
  input logic [31:0] address_o
);

  logic [2:0] pending_q;
  logic       end_beat;
  logic       res_beat;

  // strings ended but not yet popped
  assign end_beat = push & ~full & (last_i | no_char_i);
  assign res_beat = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + {2'd0, end_beat} - {2'd0, res_beat};
    end
  end

  // an invalid string reports address zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !valid_res_o) |-> (address_o == 32'd0))
    else $error("invalid result with nonzero address");

  // no result without a string that ended
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 3'd0))
    else $error("result beat without an ended string");

  // a lone ended string shows as a result once it passes both queues
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 3'd0 && end_beat && !res_beat) |=> ##1 !empty)
    else $error("result missing after string end");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(address_o) && $stable(valid_res_o)))
    else $error("waiting result changed");

endmodule

bind ipv4_text_address_parser ipv4tp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .last_i      (last_i),
  .no_char_i   (no_char_i),
  .empty       (empty),
  .pop         (pop),
  .valid_res_o (valid_res_o),
  .address_o   (address_o)
);

// ===== tb/ipv4_text_address_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_text_address_parser_tb
// Self-checking bench for the dotted-decimal IPv4 text parser. Strings go in
// one character beat at a time, and a local parse model predicts the
// valid/address beat for every finished string. Directed strings cover the
// format rules. Random strings are mostly well formed, with broken ones and
// byte noise mixed in. Both sides idle in random bursts, and the receiver
// holds off once long enough to fill the block.
// ----------------------------------------------------------------------------

module ipv4_text_address_parser_tb;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 150;
  localparam int TailCycles    = 20;
  localparam int AddrTopShift  = 24;
  localparam int SegBits       = 8;

  // clock, reset and dut ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  character_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        no_char_i   = 1'b0;
  logic        empty;
  logic        pop         = 1'b0;
  logic        valid_res_o;
  logic [31:0] address_o;

  // parse model state
  logic [1:0]  dots_seen;
  logic [1:0]  seg_digits;
  logic [9:0]  seg_value;
  logic        seg_lead_zero;
  logic        text_bad;
  logic [31:0] addr_so_far;

  ipv4tp_pkg::res_t expected_addr_q[$];
  logic [7:0]       text_q[$];

  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          quiet_cycles   = 0;
  bit          tx_idle_on     = 1'b0;
  bit          rx_idle_on     = 1'b0;
  int          hold_req_id    = 0;

  always #5 clk_i = ~clk_i;

  ipv4_text_address_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .character_i(character_i),
    .last_i     (last_i),
    .no_char_i  (no_char_i),
    .empty      (empty),
    .pop        (pop),
    .valid_res_o(valid_res_o),
    .address_o  (address_o)
  );

  // error reporting
  task automatic report_error(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // parse model: clear per-string state
  task automatic clear_parse();
    dots_seen     = '0;
    seg_digits    = '0;
    seg_value     = '0;
    seg_lead_zero = 1'b0;
    text_bad      = 1'b0;
    addr_so_far   = '0;
  endtask

  // parse model: fold one character into the string state
  task automatic parse_char(input logic [7:0] ch);
    if (!text_bad) begin
      if (ch == ipv4tp_pkg::CharDot) begin
        if (seg_digits == 2'd0 || dots_seen == ipv4tp_pkg::LastDot ||
            seg_value > ipv4tp_pkg::MaxSegment) begin
          text_bad = 1'b1;
        end else begin
          addr_so_far   = addr_so_far |
                          ({22'd0, seg_value} << (AddrTopShift - SegBits * int'(dots_seen)));
          dots_seen     = dots_seen + 2'd1;
          seg_digits    = '0;
          seg_value     = '0;
          seg_lead_zero = 1'b0;
        end
      end else if (ch >= ipv4tp_pkg::CharZero && ch <= ipv4tp_pkg::CharNine) begin
        if (seg_digits == ipv4tp_pkg::MaxDigits || (seg_digits != 2'd0 && seg_lead_zero)) begin
          text_bad = 1'b1;
        end else begin
          if (seg_digits == 2'd0 && ch == ipv4tp_pkg::CharZero) begin
            seg_lead_zero = 1'b1;
          end
          seg_value  = 10'(seg_value * 10 + {2'd0, ch - ipv4tp_pkg::CharZero});
          seg_digits = seg_digits + 2'd1;
        end
      end else begin
        text_bad = 1'b1;
      end
    end
  endtask

  // parse model: one accepted beat, queue the address beat when the string ends
  task automatic predict_address(input logic [7:0] ch, input logic lst, input logic nc);
    ipv4tp_pkg::res_t exp_res;
    logic ok;
    if (!nc) begin
      parse_char(ch);
    end
    if (nc || lst) begin
      ok = !text_bad && dots_seen == ipv4tp_pkg::LastDot && seg_digits != 2'd0 &&
           seg_value <= ipv4tp_pkg::MaxSegment;
      exp_res.valid_res = ok;
      exp_res.address   = ok ? (addr_so_far | {22'd0, seg_value}) : '0;
      expected_addr_q.push_back(exp_res);
      clear_parse();
    end
  endtask

  // send one character beat, with an optional idle burst first
  task automatic send_beat(input logic [7:0] ch, input logic lst, input logic nc);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    character_i <= ch;
    last_i      <= lst;
    no_char_i   <= nc;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_address(ch, lst, nc);
    items_sent++;
  endtask

  // send the buffered text, closed by last or by a no-char beat
  task automatic send_text_q(input bit close_nc);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      send_beat(text_q[i], !close_nc && (i == n - 1), 1'b0);
    end
    if (close_nc || n == 0) begin
      send_beat(8'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  task automatic send_text(input string s, input bit close_nc);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
    send_text_q(close_nc);
  endtask

  // stop sending and wait until every queued address beat has been checked
  task automatic wait_results_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (expected_addr_q.size() != 0);
  endtask

  // segment value biased toward the edges
  function automatic int pick_seg_value();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 9);
      3:       return $urandom_range(10, 99);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // build one random string into text_q
  task automatic build_random_text();
    int    mode;
    int    nseg;
    int    style;
    int    len;
    int    pos;
    string digits;
    text_q.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // byte noise
      len = $urandom_range(0, 12);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back(ipv4tp_pkg::CharDot);
          1:       text_q.push_back(8'($urandom));
          default: text_q.push_back(ipv4tp_pkg::CharZero + 8'($urandom_range(0, 9)));
        endcase
      end
    end else begin
      // dotted segments, broken now and then
      nseg = (mode >= 7 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 4;
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) begin
          text_q.push_back(ipv4tp_pkg::CharDot);
        end
        style = (mode >= 7) ? $urandom_range(0, 7) : 99;
        case (style)
          0:       digits = "";
          1:       digits = $sformatf("%0d", $urandom_range(256, 999));
          2:       digits = $sformatf("0%0d", $urandom_range(0, 99));
          3:       digits = $sformatf("%0d", $urandom_range(1000, 9999));
          default: digits = $sformatf("%0d", pick_seg_value());
        endcase
        for (int i = 0; i < digits.len(); i++) begin
          text_q.push_back(digits[i]);
        end
      end
      if (mode >= 7) begin
        // an empty text only takes a byte at its front
        pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 5))
          0: text_q[pos] = 8'($urandom);
          1: text_q.push_front(ipv4tp_pkg::CharDot);
          2: text_q.push_back(ipv4tp_pkg::CharDot);
          3: text_q[pos] = $urandom_range(0, 1) ? 8'h2F : 8'h3A;
          default: ;
        endcase
      end
    end
  endtask

  // directed strings: format rules and string endings
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_text("0.0.0.0", 1'b0);
    send_text("255.255.255.255", 1'b0);
    send_text("192.168.1.10", 1'b0);
    send_text("256.1.1.1", 1'b0);
    send_text("1.2.3.300", 1'b0);
    send_text("999.1.1.1", 1'b0);
    send_text("01.2.3.4", 1'b0);
    send_text("1.2.3.00", 1'b0);
    send_text("1234.1.1.1", 1'b0);
    send_text("1.2.3", 1'b0);
    send_text("1.2.3.4.5", 1'b0);
    send_text("1..3.4", 1'b0);
    send_text(".1.2.3", 1'b0);
    send_text("1.2.3.", 1'b0);
    send_text("/.1.1.:", 1'b0);
    send_text("a1.2.3.4", 1'b0);
    send_text("10.0.0.1", 1'b1);
    send_text("10.0.0", 1'b1);
    send_text("", 1'b1);
    // empty string with last set and a character that must be ignored
    send_beat(8'hFF, 1'b1, 1'b1);
    // extreme bytes inside a string
    text_q = '{8'h31, ipv4tp_pkg::CharDot, 8'h32, ipv4tp_pkg::CharDot, 8'h33,
               ipv4tp_pkg::CharDot, 8'hFF};
    send_text_q(1'b0);
    text_q = '{8'h00};
    send_text_q(1'b0);
    wait_results_drained();
  endtask

  // receiver holds off while short strings keep coming
  task automatic test_fill_stall();
    tx_idle_on = 1'b0;
    hold_req_id++;
    repeat (30) begin
      text_q = '{ipv4tp_pkg::CharZero + 8'($urandom_range(0, 9))};
      send_text_q(1'b0);
    end
    send_text("172.16.254.3", 1'b0);
    wait_results_drained();
  endtask

  // random strings with random idling on both sides
  task automatic test_random_text(input int item_target);
    int n_str;
    n_str = 0;
    while (items_sent < item_target) begin
      if (n_str % 40 == 0) begin
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      tx_idle_on = $urandom_range(0, 3) != 0;
      build_random_text();
      send_text_q($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 49) == 0) begin
        wait_results_drained();
      end
      n_str++;
    end
    wait_results_drained();
  endtask

  // back-to-back traffic, no idling on either side
  task automatic test_streaming(input int item_target);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (items_sent < item_target) begin
      build_random_text();
      send_text_q($urandom_range(0, 7) == 0);
    end
    wait_results_drained();
  endtask

  // receiver: pop with random gaps and one long hold-off on request
  int hold_done_id = 0;
  int hold_left    = 0;
  int rx_gap_left  = 0;
  always @(posedge clk_i) begin
    if (hold_req_id != hold_done_id) begin
      hold_done_id = hold_req_id;
      hold_left    = HoldCycles;
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      pop <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(1, 10) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // check each popped beat against the oldest prediction
  always @(posedge clk_i) begin
    ipv4tp_pkg::res_t exp_res;
    if (rst_ni && pop && !empty) begin
      if (expected_addr_q.size() == 0) begin
        report_error($sformatf("unexpected result: valid %0b address %08h",
                               valid_res_o, address_o));
      end else begin
        exp_res = expected_addr_q.pop_front();
        if (valid_res_o !== exp_res.valid_res) begin
          report_error($sformatf("valid_res mismatch: expected %0b, got %0b",
                                 exp_res.valid_res, valid_res_o));
        end
        if (address_o !== exp_res.address) begin
          report_error($sformatf("address mismatch: expected %08h, got %08h",
                                 exp_res.address, address_o));
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // test sequence
  initial begin
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_stall();
    test_random_text(1250);
    test_streaming(1550);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_addr_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
